// ===== rtl/i2cm_pkg.sv =====
// Shared types, command codes and sizing constants of the I2C master byte engine.
`default_nettype none

package i2cm_pkg;

  // Configuration register width and its value after reset.
  localparam int          PT_W            = 10;
  localparam logic [9:0]  PHASE_TICKS_RST = 10'd5;

  // Default width of the per-phase tick counter.
  localparam int          TICK_COUNT_BITS_DEF = 10;

  // Depth of the queue between the front and back parts.
  localparam int          QDEPTH = 2;

  typedef logic [2:0] op_t;

  localparam op_t OP_NONE    = 3'd0;
  localparam op_t OP_START   = 3'd1;
  localparam op_t OP_STOP    = 3'd2;
  localparam op_t OP_WRITE   = 3'd3;
  localparam op_t OP_RD_ACK  = 3'd4;
  localparam op_t OP_RD_NACK = 3'd5;

  // One classified tick word as it travels through the queue.
  typedef struct packed {
    op_t        cmd;
    logic [7:0] tx_byte;
    logic       sda_in;
  } item_t;

  // One result word.
  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       busy_res;
    logic       done_res;
    logic       ack_received;
    logic [7:0] rx_byte;
  } res_t;

endpackage

`default_nettype wire

// ===== rtl/i2cm_ifs.sv =====
// Valid/ready channel interfaces for the tick words and the result words.
`default_nettype none

interface i2cm_in_if;
  import i2cm_pkg::*;
  logic       valid;
  logic       ready;
  op_t        op;
  logic [7:0] tx_byte;
  logic       sda_in;

  modport source (output valid, output op, output tx_byte, output sda_in, input ready);
  modport sink   (input valid, input op, input tx_byte, input sda_in, output ready);
endinterface

interface i2cm_out_if;
  logic       valid;
  logic       ready;
  logic       scl_out;
  logic       sda_out;
  logic       busy_res;
  logic       done_res;
  logic       ack_received;
  logic [7:0] rx_byte;

  modport source (output valid, output scl_out, output sda_out, output busy_res,
                  output done_res, output ack_received, output rx_byte, input ready);
  modport sink   (input valid, input scl_out, input sda_out, input busy_res,
                  input done_res, input ack_received, input rx_byte, output ready);
endinterface

`default_nettype wire

// ===== rtl/i2cm_front.sv =====
// Front part: takes tick words and classifies the op field into a command code.
`default_nettype none

module i2cm_front (
  i2cm_in_if.sink          in_ch,
  input  wire logic        q_ready,
  output i2cm_pkg::item_t  push_item,
  output logic             push
);
  import i2cm_pkg::*;

  op_t cmd;

  // Undefined op codes carry no command.
  always_comb begin
    unique case (in_ch.op)
      OP_START, OP_STOP, OP_WRITE, OP_RD_ACK, OP_RD_NACK: cmd = in_ch.op;
      default: cmd = OP_NONE;
    endcase
  end

  assign in_ch.ready       = q_ready;
  assign push              = in_ch.valid & q_ready;
  assign push_item.cmd     = cmd;
  assign push_item.tx_byte = in_ch.tx_byte;
  assign push_item.sda_in  = in_ch.sda_in;

endmodule

`default_nettype wire

// ===== rtl/i2cm_queue.sv =====
// Short queue between the front and back parts.
`default_nettype none

module i2cm_queue (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire i2cm_pkg::item_t  push_item,
  output logic                  ready,
  input  wire logic             pop,
  output logic                  q_valid,
  output i2cm_pkg::item_t       head
);
  import i2cm_pkg::*;

  localparam int QPW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCW = $clog2(QDEPTH + 1);
  localparam logic [QPW-1:0] LAST_PTR = QPW'(QDEPTH - 1);

  item_t            mem_r [QDEPTH];
  logic [QPW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [QCW-1:0]   cnt_r,    cnt_nxt;

  assign ready   = (cnt_r != QCW'(QDEPTH));
  assign q_valid = (cnt_r != '0);
  assign head    = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + QCW'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - QCW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + QPW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + QPW'(1);
      end
      cnt_r <= cnt_nxt;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= QCW'(QDEPTH))
    else $error("queue count exceeds depth");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> q_valid)
    else $error("queue popped while empty");

endmodule

`default_nettype wire

// ===== rtl/i2cm_engine.sv =====
// Back part: the I2C bit sequencer, one tick per word, with the result register.
`default_nettype none

module i2cm_engine #(
  parameter int TICK_COUNT_BITS = i2cm_pkg::TICK_COUNT_BITS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       cfg_we,
  input  wire logic [i2cm_pkg::PT_W-1:0]  cfg_wdata,
  input  wire logic                       q_valid,
  input  wire i2cm_pkg::item_t            head,
  output logic                            pop,
  i2cm_out_if.source                      out_ch
);
  import i2cm_pkg::*;

  localparam int CW = ((TICK_COUNT_BITS > PT_W) ? TICK_COUNT_BITS : PT_W) + 1;

  localparam logic [3:0] PH_IDLE   = 4'd0;
  localparam logic [3:0] PH_ST_A   = 4'd1;
  localparam logic [3:0] PH_ST_B   = 4'd2;
  localparam logic [3:0] PH_ST_C   = 4'd3;
  localparam logic [3:0] PH_ST_D   = 4'd4;
  localparam logic [3:0] PH_SP_A   = 4'd5;
  localparam logic [3:0] PH_SP_B   = 4'd6;
  localparam logic [3:0] PH_SP_C   = 4'd7;
  localparam logic [3:0] PH_BIT_LO = 4'd8;
  localparam logic [3:0] PH_BIT_HI = 4'd9;
  localparam logic [3:0] PH_ACK_LO = 4'd10;
  localparam logic [3:0] PH_ACK_HI = 4'd11;

  localparam logic [3:0] BITS_PER_BYTE = 4'd8;

  logic [PT_W-1:0]            phase_ticks_r;
  logic [3:0]                 phase_r,  phase_nxt;
  op_t                        cmd_r,    cmd_nxt;
  logic [3:0]                 bit_cnt_r, bit_cnt_nxt;
  logic [7:0]                 shift_r,  shift_nxt;
  logic [TICK_COUNT_BITS-1:0] tick_r,   tick_nxt;
  logic                       ack_r,    ack_nxt;
  logic                       scl_r,    scl_nxt;
  logic                       sda_r,    sda_nxt;
  logic [7:0]                 rx_r,     rx_nxt;
  logic                       done;

  logic                       enter;
  logic [3:0]                 enter_ph;
  logic [PT_W-1:0]            len_eff;
  logic [CW-1:0]              tick_inc;
  logic                       last_tick;
  logic                       step;

  res_t                       res_r;
  logic                       out_valid_r;

  // A result is produced whenever a queued word waits and the result register is free or being emptied.
  assign step = q_valid && (!out_valid_r || out_ch.ready);
  assign pop  = step;

  // Phase length: zero acts as one; a length beyond the counter ends when the counter reaches all ones.
  assign len_eff   = (phase_ticks_r == '0) ? PT_W'(1) : phase_ticks_r;
  assign tick_inc  = CW'(tick_r) + CW'(1);
  assign last_tick = (tick_inc >= CW'(len_eff)) || (&tick_r);

  always_comb begin
    phase_nxt   = phase_r;
    cmd_nxt     = cmd_r;
    bit_cnt_nxt = bit_cnt_r;
    shift_nxt   = shift_r;
    tick_nxt    = tick_r;
    ack_nxt     = ack_r;
    scl_nxt     = scl_r;
    sda_nxt     = sda_r;
    rx_nxt      = rx_r;
    done        = 1'b0;
    enter       = 1'b0;
    enter_ph    = PH_IDLE;

    if (phase_r == PH_IDLE) begin
      if (head.cmd != OP_NONE) begin
        cmd_nxt     = head.cmd;
        bit_cnt_nxt = '0;
        enter       = 1'b1;
        unique case (head.cmd)
          OP_START: enter_ph = PH_ST_A;
          OP_STOP:  enter_ph = PH_SP_A;
          default: begin
            shift_nxt = (head.cmd == OP_WRITE) ? head.tx_byte : 8'h00;
            enter_ph  = PH_BIT_LO;
          end
        endcase
      end
    end else if (last_tick) begin
      unique case (phase_r)
        PH_ST_A:   begin enter = 1'b1; enter_ph = PH_ST_B;   end
        PH_ST_B:   begin enter = 1'b1; enter_ph = PH_ST_C;   end
        PH_ST_C:   begin enter = 1'b1; enter_ph = PH_ST_D;   end
        PH_SP_A:   begin enter = 1'b1; enter_ph = PH_SP_B;   end
        PH_SP_B:   begin enter = 1'b1; enter_ph = PH_SP_C;   end
        PH_BIT_LO: begin enter = 1'b1; enter_ph = PH_BIT_HI; end
        PH_ACK_LO: begin enter = 1'b1; enter_ph = PH_ACK_HI; end
        PH_BIT_HI: begin
          if (cmd_r == OP_WRITE) begin
            shift_nxt = {shift_r[6:0], 1'b0};
          end else begin
            shift_nxt = {shift_r[6:0], head.sda_in};
          end
          bit_cnt_nxt = bit_cnt_r + 4'd1;
          enter       = 1'b1;
          if (bit_cnt_nxt >= BITS_PER_BYTE) begin
            if (cmd_r != OP_WRITE) begin
              rx_nxt = shift_nxt;
            end
            enter_ph = PH_ACK_LO;
          end else begin
            enter_ph = PH_BIT_LO;
          end
        end
        PH_ACK_HI: begin
          if (cmd_r == OP_WRITE) begin
            ack_nxt = ~head.sda_in;
          end
          scl_nxt   = 1'b0;
          phase_nxt = PH_IDLE;
          tick_nxt  = '0;
          done      = 1'b1;
        end
        default: begin
          // Final phase of a start or a stop.
          phase_nxt = PH_IDLE;
          tick_nxt  = '0;
          done      = 1'b1;
        end
      endcase
    end else begin
      tick_nxt = tick_inc[TICK_COUNT_BITS-1:0];
    end

    // Entering a phase restarts the tick count and sets the line levels.
    if (enter) begin
      phase_nxt = enter_ph;
      tick_nxt  = '0;
      unique case (enter_ph)
        PH_ST_A:   sda_nxt = 1'b1;
        PH_ST_B:   scl_nxt = 1'b1;
        PH_ST_C:   sda_nxt = 1'b0;
        PH_ST_D:   scl_nxt = 1'b0;
        PH_SP_A:   sda_nxt = 1'b0;
        PH_SP_B:   scl_nxt = 1'b1;
        PH_SP_C:   sda_nxt = 1'b1;
        PH_BIT_LO: begin
          scl_nxt = 1'b0;
          sda_nxt = (cmd_nxt == OP_WRITE) ? shift_nxt[7] : 1'b1;
        end
        PH_BIT_HI: scl_nxt = 1'b1;
        PH_ACK_LO: begin
          scl_nxt = 1'b0;
          sda_nxt = (cmd_nxt == OP_RD_ACK) ? 1'b0 : 1'b1;
        end
        PH_ACK_HI: scl_nxt = 1'b1;
        default:   scl_nxt = scl_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_ticks_r <= PHASE_TICKS_RST;
      phase_r       <= PH_IDLE;
      cmd_r         <= OP_NONE;
      bit_cnt_r     <= '0;
      shift_r       <= '0;
      tick_r        <= '0;
      ack_r         <= 1'b0;
      scl_r         <= 1'b1;
      sda_r         <= 1'b1;
      rx_r          <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        phase_ticks_r <= cfg_wdata;
      end
      if (step) begin
        phase_r     <= phase_nxt;
        cmd_r       <= cmd_nxt;
        bit_cnt_r   <= bit_cnt_nxt;
        shift_r     <= shift_nxt;
        tick_r      <= tick_nxt;
        ack_r       <= ack_nxt;
        scl_r       <= scl_nxt;
        sda_r       <= sda_nxt;
        rx_r        <= rx_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res_r.scl_out      <= scl_nxt;
      res_r.sda_out      <= sda_nxt;
      res_r.busy_res     <= (phase_nxt != PH_IDLE);
      res_r.done_res     <= done;
      res_r.ack_received <= ack_nxt;
      res_r.rx_byte      <= rx_nxt;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.scl_out      = res_r.scl_out;
  assign out_ch.sda_out      = res_r.sda_out;
  assign out_ch.busy_res     = res_r.busy_res;
  assign out_ch.done_res     = res_r.done_res;
  assign out_ch.ack_received = res_r.ack_received;
  assign out_ch.rx_byte      = res_r.rx_byte;

  a_idle_tick_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_IDLE) |-> (tick_r == '0))
    else $error("tick counter running while idle");

  a_bit_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    bit_cnt_r <= BITS_PER_BYTE)
    else $error("bit counter past one byte");

  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_r.done_res) |-> !res_r.busy_res)
    else $error("done reported while still busy");

  a_byte_phase_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_BIT_LO || phase_r == PH_BIT_HI ||
     phase_r == PH_ACK_LO || phase_r == PH_ACK_HI) |->
    (cmd_r == OP_WRITE || cmd_r == OP_RD_ACK || cmd_r == OP_RD_NACK))
    else $error("byte phase without a byte command");

endmodule

`default_nettype wire

// ===== rtl/i2c_master_byte_engine_top.sv =====
// Top level of the I2C master byte engine: front classifier, queue and bit sequencer.
//
// Usage. Each word on in_ch is one bus tick: an op code (none, start, stop, write
// byte, read then ACK, read then NACK), the byte to send and the sampled SDA level.
// A command is taken only on a tick that finds the engine idle; otherwise it is
// ignored, as are the undefined op codes. Every word on in_ch gives exactly one
// word on out_ch carrying the SCL and SDA drive levels, busy, a one-tick done
// pulse, the last ack seen and the last byte read.
// The phase length in ticks is written through cfg_we/cfg_wdata while idle.
//
// Throughput is one word per cycle while out_ch does not stall: the sequencer advances
// its state by one tick per accepted word. An accepted word is written into the
// two-entry queue, and its result is then moved from the queue head into the result
// register when the sequencer steps.
// If the receiver stalls, the result register holds its word and the queue takes
// up to two more words before in_ch.ready falls.
// Reset (rst_n low at a clock edge) empties the queue and the result register,
// puts the engine idle with both lines released and sets the phase length to 5.
`default_nettype none

module i2c_master_byte_engine_top #(
  parameter int TICK_COUNT_BITS = i2cm_pkg::TICK_COUNT_BITS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       cfg_we,
  input  wire logic [i2cm_pkg::PT_W-1:0]  cfg_wdata,
  i2cm_in_if.sink                         in_ch,
  i2cm_out_if.source                      out_ch
);
  import i2cm_pkg::*;

  // Handshake between the front part and the queue.
  item_t push_item;
  logic  push;
  logic  q_ready;

  // Handshake between the queue and the sequencer.
  item_t head;
  logic  q_valid;
  logic  pop;

  i2cm_front u_front (
    .in_ch     (in_ch),
    .q_ready   (q_ready),
    .push_item (push_item),
    .push      (push)
  );

  i2cm_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .ready     (q_ready),
    .pop       (pop),
    .q_valid   (q_valid),
    .head      (head)
  );

  i2cm_engine #(
    .TICK_COUNT_BITS (TICK_COUNT_BITS)
  ) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .q_valid   (q_valid),
    .head      (head),
    .pop       (pop),
    .out_ch    (out_ch)
  );

endmodule

`default_nettype wire
